@@ design/arc_pkg.sv @@
// Shared types, status codes and microcode ROM for the address resolution cache.
package arc_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 3;

  localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd2;
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_ADD    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_MISS
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_START,
    C_MATCH,
    C_LAST
  } cond_t;

  typedef enum logic [1:0] {
    P_HOLD,
    P_CLR,
    P_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    F_NONE,
    F_HIT,
    F_MISS
  } fin_t;

  // One control word
  typedef struct packed {
    cond_t   cond_a;
    step_t   tgt_a;
    cond_t   cond_b;
    step_t   tgt_b;
    ptr_op_t ptr_op;
    logic    load;
    fin_t    fin;
  } ucode_t;

  // Condition inputs seen by the sequencer
  typedef struct packed {
    logic start;
    logic match;
    logic last;
  } cond_in_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{C_NEVER, S_IDLE, C_NEVER, S_IDLE, P_HOLD, 1'b0, F_NONE};
    unique case (s)
      S_IDLE: w = '{C_START,  S_SCAN, C_NEVER, S_IDLE, P_CLR,  1'b1, F_NONE};
      S_SCAN: w = '{C_MATCH,  S_HIT,  C_LAST,  S_MISS, P_INC,  1'b0, F_NONE};
      S_HIT:  w = '{C_ALWAYS, S_IDLE, C_NEVER, S_IDLE, P_CLR,  1'b0, F_HIT};
      S_MISS: w = '{C_ALWAYS, S_IDLE, C_NEVER, S_IDLE, P_CLR,  1'b0, F_MISS};
      default: w = '{C_ALWAYS, S_IDLE, C_NEVER, S_IDLE, P_CLR, 1'b0, F_NONE};
    endcase
    return w;
  endfunction

  function automatic logic cond_true(cond_t c, cond_in_t f);
    logic r;
    r = 1'b0;
    unique case (c)
      C_NEVER:  r = 1'b0;
      C_ALWAYS: r = 1'b1;
      C_START:  r = f.start;
      C_MATCH:  r = f.match;
      C_LAST:   r = f.last;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ design/arc_useq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module arc_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  arc_pkg::cond_in_t cin,
  output arc_pkg::ucode_t   ctl,
  output logic              busy
);
  import arc_pkg::*;

  step_t step_r;
  step_t step_nxt;

  always_comb begin
    priority if (cond_true(ctl.cond_a, cin)) begin
      step_nxt = ctl.tgt_a;
    end else if (cond_true(ctl.cond_b, cin)) begin
      step_nxt = ctl.tgt_b;
    end else begin
      step_nxt = step_r;
    end
  end

  always_comb begin
    ctl  = ucode_rom(step_r);
    busy = (step_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ design/arc_dpath.sv @@
// Datapath: entry memories, valid bits, scan pointer and result registers.
module arc_dpath #(
  parameter int ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arc_pkg::ucode_t               ctl,
  input  logic                          start,
  input  logic                          in_func,
  input  logic [arc_pkg::IP_W-1:0]      in_ip_address,
  input  logic [arc_pkg::MAC_W-1:0]     in_mac_address,
  output logic                          match,
  output logic                          last,
  output logic                          out_strobe,
  output logic [arc_pkg::STAT_W-1:0]    out_status,
  output logic [arc_pkg::IDX_W-1:0]     out_entry_index,
  output logic [arc_pkg::MAC_W-1:0]     out_mac_result
);
  import arc_pkg::*;

  localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];

  logic             func_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic             free_found_r, free_found_nxt;
  logic [PTR_W-1:0] free_idx_r, free_idx_nxt;
  logic [IP_W-1:0]  rd_ip_r;
  logic [MAC_W-1:0] rd_mac_r;

  logic             ip_we, mac_we;
  logic [PTR_W-1:0] wr_addr;

  logic              strobe_r, strobe_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]  index_r, index_nxt;
  logic [MAC_W-1:0]  mres_r, mres_nxt;

  // Read data always belongs to the entry at ptr_r
  assign match = valid_r[ptr_r] && (rd_ip_r == ip_r);
  assign last  = (ptr_r == PTR_W'(ENTRIES - 1));

  always_comb begin
    unique case (ctl.ptr_op)
      P_HOLD:  ptr_nxt = ptr_r;
      P_CLR:   ptr_nxt = '0;
      P_INC:   ptr_nxt = (match || last) ? ptr_r : ptr_r + PTR_W'(1);
      default: ptr_nxt = ptr_r;
    endcase
  end

  // First free slot seen during the scan
  always_comb begin
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    if (ctl.load && start) begin
      free_found_nxt = 1'b0;
    end else if (ctl.ptr_op == P_INC && !valid_r[ptr_r] && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = ptr_r;
    end
  end

  always_comb begin
    ip_we      = 1'b0;
    mac_we     = 1'b0;
    wr_addr    = ptr_r;
    valid_nxt  = valid_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    index_nxt  = index_r;
    mres_nxt   = mres_r;
    unique case (ctl.fin)
      F_NONE: begin
      end
      F_HIT: begin
        strobe_nxt = 1'b1;
        index_nxt  = IDX_W'(ptr_r);
        if (func_r == FUNC_LOOKUP) begin
          status_nxt = ST_HIT;
          mres_nxt   = rd_mac_r;
        end else begin
          mac_we     = 1'b1;
          status_nxt = ST_UPDATED;
          mres_nxt   = '0;
        end
      end
      F_MISS: begin
        strobe_nxt = 1'b1;
        mres_nxt   = '0;
        index_nxt  = '0;
        if (func_r == FUNC_LOOKUP) begin
          status_nxt = ST_MISS;
        end else if (free_found_r) begin
          ip_we      = 1'b1;
          mac_we     = 1'b1;
          wr_addr    = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          status_nxt = ST_ADDED;
          index_nxt  = IDX_W'(free_idx_r);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ip_we) begin
      ip_mem[wr_addr] <= ip_r;
    end
    rd_ip_r <= ip_mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[wr_addr] <= mac_r;
    end
    rd_mac_r <= mac_mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      valid_r      <= '0;
      free_found_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      ptr_r        <= ptr_nxt;
      valid_r      <= valid_nxt;
      free_found_r <= free_found_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && start) begin
      func_r <= in_func;
      ip_r   <= in_ip_address;
      mac_r  <= in_mac_address;
    end
    free_idx_r <= free_idx_nxt;
    status_r   <= status_nxt;
    index_r    <= index_nxt;
    mres_r     <= mres_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_index = index_r;
  assign out_mac_result  = mres_r;

endmodule

@@ design/address_resolution_cache_unit.sv @@
// Address resolution cache: IPv4 to MAC table scanned one entry per cycle.
// An accepted command scans entries in order until a match or the last entry,
// then one finish step writes back and registers the result; the strobe comes
// from that result register, once the scan state and then the finish state have run.
// busy stays high through scan and finish; the next command can be taken in the
// strobe cycle. The receiver cannot stall. Reset clears all valid bits at once.
module address_resolution_cache_unit #(
  parameter int ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [arc_pkg::IP_W-1:0]      in_ip_address,
  input  logic [arc_pkg::MAC_W-1:0]     in_mac_address,
  output logic                          out_strobe,
  output logic [arc_pkg::STAT_W-1:0]    out_status,
  output logic [arc_pkg::IDX_W-1:0]     out_entry_index,
  output logic [arc_pkg::MAC_W-1:0]     out_mac_result
);
  import arc_pkg::*;

  ucode_t   ctl;
  cond_in_t cin;
  logic     match;
  logic     last;

  assign cin.start = start;
  assign cin.match = match;
  assign cin.last  = last;

  arc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .cin   (cin),
    .ctl   (ctl),
    .busy  (busy)
  );

  arc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .start           (start),
    .in_func         (in_func),
    .in_ip_address   (in_ip_address),
    .in_mac_address  (in_mac_address),
    .match           (match),
    .last            (last),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_mac_result  (out_mac_result)
  );

endmodule
